@@ src/dsf_pkg.sv @@
// Shared types and constants for the decimal sentence framer.
package dsf_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_DOLLAR,
    PH_DIGIT,
    PH_COMMA,
    PH_STAR,
    PH_CKH,
    PH_CKL,
    PH_CR,
    PH_LF
  } phase_e;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // v / 10 == (v * DIV10_MUL) >> DIV10_SHIFT for every 32-bit v
  localparam logic [31:0]  DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int unsigned  DIV10_SHIFT = 35;

endpackage

@@ src/dsf_front.sv @@
// Front end: accepts items and converts values to decimal digits, one per cycle.
module dsf_front
  import dsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  push_o,
  output logic [DIGITS*4:0]     push_data_o,
  input  logic                  full_i
);

  localparam int CW = $clog2(DIGITS + 1);

  logic                     hold_valid_q, hold_valid_d;
  logic                     type_q, type_d;
  logic [31:0]              v_q, v_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [DIGITS-1:0][3:0]   digs_q, digs_d;

  logic        done;
  logic        accept;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem;

  assign prod = 64'(v_q) * 64'(DIV10_MUL);
  assign quot = 32'(prod[63:DIV10_SHIFT]);
  assign rem  = v_q - ((quot << 3) + (quot << 1));

  assign done        = (type_q == REQ_CLOSE) || (cnt_q == CW'(DIGITS));
  assign push_o      = hold_valid_q && done && !full_i;
  assign in_stall_o  = hold_valid_q && !push_o;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = {type_q, digs_q};

  always_comb begin
    hold_valid_d = hold_valid_q;
    type_d       = type_q;
    v_d          = v_q;
    cnt_d        = cnt_q;
    digs_d       = digs_q;
    if (accept) begin
      hold_valid_d = 1'b1;
      type_d       = in_item_i.req_type;
      v_d          = in_item_i.value;
      cnt_d        = '0;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end else if (hold_valid_q && !done) begin
      // least significant digit first, shifted in from the top
      for (int k = 0; k < DIGITS - 1; k++) begin
        digs_d[k] = digs_q[k + 1];
      end
      digs_d[DIGITS-1] = rem[3:0];
      v_d   = quot;
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    v_q    <= v_d;
    cnt_q  <= cnt_d;
    digs_q <= digs_d;
  end

endmodule

@@ src/dsf_fifo.sv @@
// Two-entry queue between front and back.
module dsf_fifo #(
  parameter int WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/dsf_back.sv @@
// Back end: sequences sentence bytes into the output register, tracks checksum.
module dsf_back
  import dsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  logic [DIGITS*4:0] head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int DCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [DCW-1:0] DCNT_INIT = DCW'(DIGITS - 1);

  phase_e           phase_q, phase_d, act;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic             open_q, open_d;
  logic [7:0]       xor_q, xor_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic                   head_close;
  logic [DIGITS-1:0][3:0] digs;
  logic                   out_free;
  logic                   fire;
  logic [7:0]             ch;
  logic                   last;

  assign head_close  = head_i[DIGITS*4];
  assign digs        = head_i[DIGITS*4-1:0];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    if (phase_q != PH_START) begin
      act = phase_q;
    end else if (!open_q) begin
      act = PH_DOLLAR;
    end else if (head_close == REQ_CLOSE) begin
      act = PH_STAR;
    end else begin
      act = PH_DIGIT;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    dcnt_d      = dcnt_q;
    open_d      = open_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    pop_o       = 1'b0;
    fire        = 1'b0;
    ch          = CH_ZERO;
    last        = 1'b0;
    if (!empty_i && out_free) begin
      fire = 1'b1;
      unique case (act)
        PH_DOLLAR: begin
          ch      = CH_DOLLAR;
          phase_d = (head_close == REQ_CLOSE) ? PH_STAR : PH_DIGIT;
        end
        PH_DIGIT: begin
          ch      = {4'h3, digs[dcnt_q]};
          xor_d   = xor_q ^ ch;
          if (dcnt_q == '0) begin
            phase_d = PH_COMMA;
          end else begin
            phase_d = PH_DIGIT;
            dcnt_d  = dcnt_q - DCW'(1);
          end
        end
        PH_COMMA: begin
          ch      = CH_COMMA;
          last    = 1'b1;
          open_d  = 1'b1;
          dcnt_d  = DCNT_INIT;
          phase_d = PH_START;
        end
        PH_STAR: begin
          ch      = CH_STAR;
          phase_d = PH_CKH;
        end
        PH_CKH: begin
          ch      = {4'h0, xor_q[7:4]} + CH_ZERO;
          phase_d = PH_CKL;
        end
        PH_CKL: begin
          ch      = {4'h0, xor_q[3:0]} + CH_ZERO;
          phase_d = PH_CR;
        end
        PH_CR: begin
          ch      = CH_CR;
          phase_d = PH_LF;
        end
        PH_LF: begin
          ch      = CH_LF;
          last    = 1'b1;
          open_d  = 1'b0;
          xor_d   = 8'h00;
          dcnt_d  = DCNT_INIT;
          phase_d = PH_START;
        end
        PH_START: begin
          fire = 1'b0;
        end
        default: begin
          fire = 1'b0;
        end
      endcase
      if (fire) begin
        out_valid_d            = 1'b1;
        out_item_d.out_char    = ch;
        out_item_d.last_of_run = last;
        pop_o                  = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      dcnt_q      <= DCNT_INIT;
      open_q      <= 1'b0;
      xor_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      dcnt_q      <= dcnt_d;
      open_q      <= open_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

@@ src/decimal_sentence_framer_core.sv @@
// Throughput: one output byte per cycle while out_stall_i is low and the queue holds an item;
// a value item yields DIGITS+1 or DIGITS+2 bytes, a close item 5 or 6, as set by the
// back end's byte sequencer.
// Decimal conversion runs one digit per cycle beside the output.
// Reset is asynchronous, active low: no sentence open, checksum cleared, queue empty.
module decimal_sentence_framer_core
  import dsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int EW = DIGITS * 4 + 1;

  logic          push;
  logic [EW-1:0] push_data;
  logic          full;
  logic          pop;
  logic          empty;
  logic [EW-1:0] head;

  dsf_front #(.DIGITS(DIGITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  dsf_fifo #(.WIDTH(EW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  dsf_back #(.DIGITS(DIGITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ verif/tb_decimal_sentence_framer_core.sv @@
// Testbench for decimal_sentence_framer_core: predicts each sentence byte and checks the output.
module tb_decimal_sentence_framer_core;
  import dsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS      = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  decimal_sentence_framer_core #(.DIGITS(DIGITS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic       sentence_is_open = 1'b0;
  logic [7:0] checksum_acc = 8'h00;
  out_item_t  expected_bytes[$];

  bit idle_on = 1'b1;
  int hold_req = 0;
  int fail_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int sentences_closed = 0;
  int empty_closes = 0;
  int max_hold_stall = 0;
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("tb: mismatch at %0t ns: %s", $realtime, what);
  endtask

  function automatic void frame_item(input in_item_t item);
    logic [7:0]  chars[$];
    logic [7:0]  digs[DIGITS];
    logic [31:0] v;
    out_item_t   b;
    if (!sentence_is_open) chars.push_back(CH_DOLLAR);
    if (item.req_type == REQ_DATA) begin
      v = item.value;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        digs[i] = CH_ZERO + 8'(v % 10);
        v = v / 10;
      end
      for (int i = 0; i < DIGITS; i++) begin
        checksum_acc ^= digs[i];
        chars.push_back(digs[i]);
      end
      chars.push_back(CH_COMMA);
      sentence_is_open = 1'b1;
    end else begin
      if (!sentence_is_open) empty_closes++;
      sentences_closed++;
      chars.push_back(CH_STAR);
      chars.push_back(CH_ZERO + {4'h0, checksum_acc[7:4]});
      chars.push_back(CH_ZERO + {4'h0, checksum_acc[3:0]});
      chars.push_back(CH_CR);
      chars.push_back(CH_LF);
      sentence_is_open = 1'b0;
      checksum_acc = 8'h00;
    end
    foreach (chars[i]) begin
      b.out_char    = chars[i];
      b.last_of_run = (i == chars.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  task automatic check_byte(input out_item_t got);
    out_item_t exp;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %h", got.out_char));
      return;
    end
    exp = expected_bytes.pop_front();
    bytes_checked++;
    if (got.out_char !== exp.out_char)
      report_mismatch($sformatf("out_char %h, expected %h", got.out_char, exp.out_char));
    if (got.last_of_run !== exp.last_of_run)
      report_mismatch($sformatf("last_of_run %b, expected %b on byte %h",
                                got.last_of_run, exp.last_of_run, exp.out_char));
  endtask

  // receive side: checks, random stall bursts, and long hold-offs on request
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_byte(out_item_o);
      if (rst_ni && in_valid_i && in_stall_o && hold_left > 0) max_hold_stall++;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic kind, input logic [31:0] val);
    in_item_t item;
    item.req_type = kind;
    item.value    = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    frame_item(item);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned hi;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 99999999);
      1:       return $urandom_range(0, 9);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3: begin
        hi = $urandom_range(0, 42);
        return hi * 100000000 + $urandom_range(0, 9);
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_item(REQ_CLOSE, 32'h0);            // close with nothing open
    send_item(REQ_CLOSE, 32'hFFFF_FFFF);
    send_item(REQ_DATA, 32'd0);
    send_item(REQ_CLOSE, 32'h0);
    send_item(REQ_DATA, 32'hFFFF_FFFF);     // digits above the eighth dropped
    send_item(REQ_DATA, 32'd99999999);
    send_item(REQ_DATA, 32'd100000000);
    send_item(REQ_CLOSE, 32'h5555_5555);
    send_item(REQ_DATA, 32'd9);             // 9 ^ 6 puts '?' in the checksum
    send_item(REQ_DATA, 32'd6);
    send_item(REQ_CLOSE, 32'h0);
    send_item(REQ_DATA, 32'd1);
    send_item(REQ_CLOSE, 32'h0);
    send_item(REQ_DATA, 32'hAAAA_AAAA);
    send_item(REQ_DATA, 32'h5555_5555);
    send_item(REQ_DATA, 32'd12345678);
    send_item(REQ_CLOSE, 32'hAAAA_AAAA);
    send_item(REQ_CLOSE, 32'h0);
  endtask

  task automatic test_random_sentences(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(REQ_CLOSE, $urandom());
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(REQ_DATA, pick_value());
        sent += len;
        if ($urandom_range(0, 9) != 0) begin
          send_item(REQ_CLOSE, $urandom());
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 300;
    repeat (12) begin
      repeat ($urandom_range(1, 3)) send_item(REQ_DATA, pick_value());
      send_item(REQ_CLOSE, $urandom());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle(input int n_sentences);
    idle_on = 1'b0;
    repeat (n_sentences) begin
      repeat ($urandom_range(1, 4)) send_item(REQ_DATA, pick_value());
      send_item(REQ_CLOSE, $urandom());
    end
  endtask

  initial begin : main_seq
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sentences(300);
    test_backpressure();
    test_no_idle(16);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (3 * (DIGITS + 2)) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    $display("tb: %0d items in, %0d bytes checked, %0d sentences closed (%0d empty)",
             items_sent, bytes_checked, sentences_closed, empty_closes);
    $display("tb: input held back %0d cycles during the long output hold-off",
             max_hold_stall);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
